FILE: src/fse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame stack engine package
// Field widths, operation and status codes, and the descriptor that follows
// an item from the control stage to the result stage.
// ----------------------------------------------------------------------------
package fse_pkg;

  localparam int unsigned DepthDefault = 1024;
  localparam int unsigned WordW        = 64;
  localparam int unsigned IdxW         = 11;
  localparam int unsigned ModeW        = 3;
  localparam int unsigned StatusW      = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH     = 3'd0,
    MODE_POP      = 3'd1,
    MODE_ALLOC    = 3'd2,
    MODE_FREE     = 3'd3,
    MODE_PEEK     = 3'd4,
    MODE_PEEK_REL = 3'd5,
    MODE_POKE     = 3'd6,
    MODE_POKE_REL = 3'd7
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic                rd_en;
    logic [IdxW-1:0]     frame_base;
    logic [IdxW-1:0]     depth_now;
    status_e             status;
  } resp_meta_t;

endpackage
`default_nettype wire

FILE: src/fse_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame stack engine request channel
// Valid/ready channel that carries one stack operation per item.
// ----------------------------------------------------------------------------
interface fse_in_if;
  logic                             valid;
  logic                             ready;
  fse_pkg::mode_e                   mode;
  logic [fse_pkg::WordW-1:0]        value;
  logic [fse_pkg::IdxW-1:0]         position;
  logic [fse_pkg::IdxW-1:0]         amount;

  modport source (output valid, output mode, output value, output position,
                  output amount, input ready);
  modport sink   (input valid, input mode, input value, input position,
                  input amount, output ready);
endinterface
`default_nettype wire

FILE: src/fse_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame stack engine result channel
// Valid/ready channel that carries one result per item.
// ----------------------------------------------------------------------------
interface fse_out_if;
  logic                             valid;
  logic                             ready;
  logic [fse_pkg::WordW-1:0]        read_word;
  logic [fse_pkg::IdxW-1:0]         frame_base;
  logic [fse_pkg::IdxW-1:0]         depth_now;
  fse_pkg::status_e                 status;

  modport source (output valid, output read_word, output frame_base,
                  output depth_now, output status, input ready);
  modport sink   (input valid, input read_word, input frame_base,
                  input depth_now, input status, output ready);
endinterface
`default_nettype wire

FILE: src/fse_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame stack engine RAM
// Single-port synchronous RAM with a registered read that holds its data
// until the next read.
// ----------------------------------------------------------------------------
module fse_ram #(
  parameter int unsigned Width = fse_pkg::WordW,
  parameter int unsigned Depth = fse_pkg::DepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: src/fse_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame stack engine control
// Holds the stack pointer, checks each operation, issues the one memory access
// it needs, if it needs any, and runs the clearing sweep after reset.
// ----------------------------------------------------------------------------
module fse_ctrl #(
  parameter int unsigned DEPTH = fse_pkg::DepthDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  fse_in_if.sink                           req_i,
  output logic                             s1_valid_o,
  output fse_pkg::resp_meta_t              meta_o,
  input  wire logic                        s1_ready_i,
  output logic                             ram_en_o,
  output logic                             ram_we_o,
  output logic [$clog2(DEPTH)-1:0]         ram_addr_o,
  output logic [fse_pkg::WordW-1:0]        ram_wdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned CW = ((PW > fse_pkg::IdxW) ? PW : fse_pkg::IdxW) + 1;
  localparam logic [CW-1:0] DepthX = CW'(DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  logic [PW-1:0]         ptr_q;
  logic                  clear_q;
  logic [AW-1:0]         clr_cnt_q;
  logic                  s1_valid_q;
  fse_pkg::resp_meta_t   meta_q;

  logic [CW-1:0]         ptr_x;
  logic [CW-1:0]         pos_x;
  logic [CW-1:0]         amt_x;
  logic [CW-1:0]         ptr_n;
  logic [CW-1:0]         loc;
  logic [CW-1:0]         acc_addr;
  logic [CW-1:0]         base;
  logic                  acc_en;
  logic                  acc_we;
  logic                  rd_en;
  logic                  rel;
  logic                  bad;
  logic                  accept;
  fse_pkg::status_e      st;

  assign req_i.ready = !clear_q && (!s1_valid_q || s1_ready_i);
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    ptr_x    = CW'(ptr_q);
    pos_x    = CW'(req_i.position);
    amt_x    = CW'(req_i.amount);
    ptr_n    = ptr_x;
    st       = fse_pkg::ST_OK;
    base     = '0;
    acc_en   = 1'b0;
    acc_we   = 1'b0;
    rd_en    = 1'b0;
    acc_addr = '0;
    rel      = req_i.mode inside {fse_pkg::MODE_PEEK_REL, fse_pkg::MODE_POKE_REL};
    if (rel) begin
      bad = (pos_x == '0) || (pos_x > ptr_x);
      loc = ptr_x - pos_x;
    end else begin
      bad = (pos_x >= ptr_x);
      loc = pos_x;
    end
    case (req_i.mode)
      fse_pkg::MODE_PUSH: begin
        if (ptr_x >= DepthX) begin
          st = fse_pkg::ST_OVER;
        end else begin
          acc_en   = 1'b1;
          acc_we   = 1'b1;
          acc_addr = ptr_x;
          ptr_n    = ptr_x + CW'(1);
        end
      end
      fse_pkg::MODE_POP: begin
        if (ptr_x == '0) begin
          st = fse_pkg::ST_UNDER;
        end else begin
          acc_en   = 1'b1;
          rd_en    = 1'b1;
          acc_addr = ptr_x - CW'(1);
          ptr_n    = ptr_x - CW'(1);
        end
      end
      fse_pkg::MODE_ALLOC: begin
        if (ptr_x + amt_x > DepthX) begin
          st = fse_pkg::ST_OVER;
        end else begin
          base  = ptr_x;
          ptr_n = ptr_x + amt_x;
        end
      end
      fse_pkg::MODE_FREE: begin
        if (amt_x > ptr_x) begin
          st = fse_pkg::ST_UNDER;
        end else begin
          ptr_n = ptr_x - amt_x;
        end
      end
      fse_pkg::MODE_PEEK, fse_pkg::MODE_PEEK_REL,
      fse_pkg::MODE_POKE, fse_pkg::MODE_POKE_REL: begin
        if (bad) begin
          st = fse_pkg::ST_RANGE;
        end else begin
          acc_en   = 1'b1;
          acc_we   = req_i.mode inside {fse_pkg::MODE_POKE, fse_pkg::MODE_POKE_REL};
          rd_en    = !acc_we;
          acc_addr = loc;
        end
      end
      default: begin
        st = fse_pkg::ST_RANGE;
      end
    endcase
  end

  always_comb begin
    if (clear_q) begin
      ram_en_o    = 1'b1;
      ram_we_o    = 1'b1;
      ram_addr_o  = clr_cnt_q;
      ram_wdata_o = '0;
    end else begin
      ram_en_o    = accept && acc_en;
      ram_we_o    = acc_we;
      ram_addr_o  = acc_addr[AW-1:0];
      ram_wdata_o = req_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      clear_q    <= 1'b1;
      clr_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (clear_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == LastAddr) begin
          clear_q <= 1'b0;
        end
      end
      if (accept) begin
        ptr_q      <= ptr_n[PW-1:0];
        s1_valid_q <= 1'b1;
      end else if (s1_ready_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meta_q.rd_en      <= rd_en;
      meta_q.frame_base <= fse_pkg::IdxW'(base);
      meta_q.depth_now  <= fse_pkg::IdxW'(ptr_n);
      meta_q.status     <= st;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign meta_o     = meta_q;

`ifndef SYNTHESIS
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(ptr_q) <= DepthX)
    else $error("Stack pointer exceeds the store depth.");

  a_fail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (st != fse_pkg::ST_OK) |=> $stable(ptr_q))
    else $error("A failed operation changed the stack pointer.");

  a_push_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.mode == fse_pkg::MODE_PUSH) && (st == fse_pkg::ST_OK)
    |=> ptr_q == PW'($past(ptr_q) + PW'(1)))
    else $error("A push did not raise the stack pointer by one.");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_ready_i |=> s1_valid_q)
    else $error("A pending item was dropped while the result stage stalled.");
`endif

endmodule
`default_nettype wire

FILE: src/fse_resp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame stack engine result stage
// Joins the memory read data with the item descriptor and holds the result
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module fse_resp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s1_valid_i,
  input  wire fse_pkg::resp_meta_t         meta_i,
  input  wire logic [fse_pkg::WordW-1:0]   rdata_i,
  output logic                             s1_ready_o,
  fse_out_if.source                        rsp_o
);

  logic                          out_valid_q;
  logic [fse_pkg::WordW-1:0]     read_word_q;
  logic [fse_pkg::IdxW-1:0]      frame_base_q;
  logic [fse_pkg::IdxW-1:0]      depth_now_q;
  fse_pkg::status_e              status_q;

  assign s1_ready_o = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready_o && s1_valid_i) begin
      read_word_q  <= meta_i.rd_en ? rdata_i : '0;
      frame_base_q <= meta_i.frame_base;
      depth_now_q  <= meta_i.depth_now;
      status_q     <= meta_i.status;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_word  = read_word_q;
  assign rsp_o.frame_base = frame_base_q;
  assign rsp_o.depth_now  = depth_now_q;
  assign rsp_o.status     = status_q;

endmodule
`default_nettype wire

FILE: src/frame_stack_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame stack engine
// Word stack with frame allocation, peek and poke for a bytecode interpreter.
// ----------------------------------------------------------------------------
// The engine takes one stack operation per cycle as long as results are taken.
// Each accepted item's result passes through the access to the single-port
// word store, registered with the item's descriptor, and then through the
// output register. Every operation needs at most one store access, so that port
// sets the rate of one item per cycle. After reset the engine clears the store,
// one word a cycle, and accepts no item until every word of it is cleared.
// Failed operations report their status and change neither the pointer nor the
// store.
module frame_stack_engine #(
  parameter int unsigned DEPTH = fse_pkg::DepthDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fse_in_if.sink      req_i,
  fse_out_if.source   rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                          s1_valid;
  logic                          s1_ready;
  fse_pkg::resp_meta_t           meta;
  logic                          ram_en;
  logic                          ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [fse_pkg::WordW-1:0]     ram_wdata;
  logic [fse_pkg::WordW-1:0]     ram_rdata;

  fse_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .s1_valid_o  (s1_valid),
    .meta_o      (meta),
    .s1_ready_i  (s1_ready),
    .ram_en_o    (ram_en),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata)
  );

  fse_ram #(
    .Width (fse_pkg::WordW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  fse_resp u_resp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .meta_i     (meta),
    .rdata_i    (ram_rdata),
    .s1_ready_o (s1_ready),
    .rsp_o      (rsp_o)
  );

endmodule
`default_nettype wire

FILE: dv/frame_stack_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame stack engine testbench
// Drives push, pop, alloc, free, peek and poke items through the request
// channel under bursty traffic and receiver stalls. A behavioral model of the
// stack predicts each result, and every result is checked field by field.
// ----------------------------------------------------------------------------
module frame_stack_engine_tb;

  localparam int unsigned DEPTH     = fse_pkg::DepthDefault;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned CYC_LIMIT = 300000;

  typedef struct {
    fse_pkg::mode_e                mode;
    logic [fse_pkg::WordW-1:0]     value;
    logic [fse_pkg::IdxW-1:0]      position;
    logic [fse_pkg::IdxW-1:0]      amount;
  } stack_op_t;

  typedef struct {
    logic [fse_pkg::WordW-1:0]     read_word;
    logic [fse_pkg::IdxW-1:0]      frame_base;
    logic [fse_pkg::IdxW-1:0]      depth_now;
    fse_pkg::status_e              status;
  } stack_rsp_t;

  logic clk_i;
  logic rst_ni;

  fse_in_if  req_if ();
  fse_out_if rsp_if ();

  frame_stack_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  stack_op_t   pending_ops[$];
  stack_rsp_t  expected_rsps[$];
  stack_op_t   cur_op;
  logic [fse_pkg::WordW-1:0] word_model [DEPTH];
  int unsigned top_model;
  int unsigned gen_top;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned rdy_count;
  int unsigned cycles;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned status_seen [4];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Applies one operation to the model stack and returns its result.
  function automatic stack_rsp_t stack_apply(stack_op_t op);
    stack_rsp_t  r;
    int unsigned addr;
    int unsigned pos;
    logic        in_range;
    r.read_word  = '0;
    r.frame_base = '0;
    r.status     = fse_pkg::ST_OK;
    pos          = 32'(op.position);
    case (op.mode)
      fse_pkg::MODE_PUSH: begin
        if (top_model >= DEPTH) begin
          r.status = fse_pkg::ST_OVER;
        end else begin
          word_model[top_model[AW-1:0]] = op.value;
          top_model++;
        end
      end
      fse_pkg::MODE_POP: begin
        if (top_model == 0) begin
          r.status = fse_pkg::ST_UNDER;
        end else begin
          top_model--;
          r.read_word = word_model[top_model[AW-1:0]];
        end
      end
      fse_pkg::MODE_ALLOC: begin
        if (top_model + op.amount > DEPTH) begin
          r.status = fse_pkg::ST_OVER;
        end else begin
          r.frame_base = top_model[fse_pkg::IdxW-1:0];
          top_model += op.amount;
        end
      end
      fse_pkg::MODE_FREE: begin
        if (op.amount > top_model) begin
          r.status = fse_pkg::ST_UNDER;
        end else begin
          top_model -= op.amount;
        end
      end
      default: begin
        if (op.mode inside {fse_pkg::MODE_PEEK_REL, fse_pkg::MODE_POKE_REL}) begin
          in_range = (pos != 0) && (pos <= top_model);
          addr = top_model - pos;
        end else begin
          in_range = pos < top_model;
          addr = pos;
        end
        if (!in_range) begin
          r.status = fse_pkg::ST_RANGE;
        end else if (op.mode inside {fse_pkg::MODE_PEEK, fse_pkg::MODE_PEEK_REL}) begin
          r.read_word = word_model[addr[AW-1:0]];
        end else begin
          word_model[addr[AW-1:0]] = op.value;
        end
      end
    endcase
    r.depth_now = top_model[fse_pkg::IdxW-1:0];
    return r;
  endfunction

  // Queues an item and follows the pointer so that later items can target it.
  task automatic queue_op(fse_pkg::mode_e m, logic [fse_pkg::WordW-1:0] v,
                          int unsigned p, int unsigned a);
    stack_op_t op;
    op.mode     = m;
    op.value    = v;
    op.position = p[fse_pkg::IdxW-1:0];
    op.amount   = a[fse_pkg::IdxW-1:0];
    pending_ops.push_back(op);
    case (m)
      fse_pkg::MODE_PUSH:  if (gen_top < DEPTH) gen_top++;
      fse_pkg::MODE_POP:   if (gen_top > 0) gen_top--;
      fse_pkg::MODE_ALLOC: if (gen_top + a <= DEPTH) gen_top += a;
      fse_pkg::MODE_FREE:  if (a <= gen_top) gen_top -= a;
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.mode     <= fse_pkg::MODE_PUSH;
      req_if.value    <= '0;
      req_if.position <= '0;
      req_if.amount   <= '0;
      burst_left      <= 0;
      gap_left        <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.push_back(stack_apply(cur_op));
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          req_if.valid    <= 1'b1;
          req_if.mode     <= cur_op.mode;
          req_if.value    <= cur_op.value;
          req_if.position <= cur_op.position;
          req_if.amount   <= cur_op.amount;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    stack_rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
      rdy_count    <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("%0t: unexpected result, no item pending", $realtime);
          end
        end else begin
          exp_rsp = expected_rsps.pop_front();
          n_checked++;
          status_seen[exp_rsp.status]++;
          if (rsp_if.read_word !== exp_rsp.read_word ||
              rsp_if.frame_base !== exp_rsp.frame_base ||
              rsp_if.depth_now !== exp_rsp.depth_now ||
              rsp_if.status !== exp_rsp.status) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("%0t: mismatch on result %0d", $realtime, n_checked);
              $display("  expected word=%h base=%0d depth=%0d status=%s",
                       exp_rsp.read_word, exp_rsp.frame_base, exp_rsp.depth_now,
                       exp_rsp.status.name());
              $display("  actual   word=%h base=%0d depth=%0d status=%0d",
                       rsp_if.read_word, rsp_if.frame_base, rsp_if.depth_now,
                       rsp_if.status);
            end
          end
        end
      end
      rdy_count <= rdy_count + 1;
      case ((rdy_count / 150) % 4)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 2) != 0);
        2: rsp_if.ready <= ((rdy_count % 7) < 4);
        default: begin
          if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
          end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 19) == 0) stall_left <= $urandom_range(5, 30);
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, expected_rsps.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned pos;
    int unsigned amt;
    logic [fse_pkg::WordW-1:0] val;
    fse_pkg::mode_e m;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.mode     = fse_pkg::MODE_PUSH;
    req_if.value    = '0;
    req_if.position = '0;
    req_if.amount   = '0;
    rsp_if.ready    = 1'b0;
    cycles          = 0;
    n_checked       = 0;
    n_errors        = 0;
    top_model       = 0;
    gen_top         = 0;
    status_seen     = '{default: 0};
    word_model      = '{default: '0};

    // Edge cases on an empty stack, at both ends of each field, and on a full stack.
    queue_op(fse_pkg::MODE_POP,      '0,              0,    0);
    queue_op(fse_pkg::MODE_PEEK,     '0,              0,    0);
    queue_op(fse_pkg::MODE_PEEK_REL, '0,              0,    0);
    queue_op(fse_pkg::MODE_FREE,     '0,              0,    1);
    queue_op(fse_pkg::MODE_ALLOC,    '0,              0,    0);
    queue_op(fse_pkg::MODE_FREE,     '0,              0,    0);
    queue_op(fse_pkg::MODE_PUSH,     '1,              1024, 1024);
    queue_op(fse_pkg::MODE_PUSH,     '0,              0,    0);
    queue_op(fse_pkg::MODE_PEEK,     '0,              0,    0);
    queue_op(fse_pkg::MODE_PEEK_REL, '0,              1,    0);
    queue_op(fse_pkg::MODE_POKE,     64'h5a5a_a5a5_0f0f_f0f0, 1, 0);
    queue_op(fse_pkg::MODE_POKE_REL, 64'h0123_4567_89ab_cdef, 2, 0);
    queue_op(fse_pkg::MODE_POKE_REL, '1,              0,    0);
    queue_op(fse_pkg::MODE_PEEK_REL, '0,              3,    0);
    queue_op(fse_pkg::MODE_ALLOC,    '0,              0,    1024);
    queue_op(fse_pkg::MODE_ALLOC,    '0,              0,    1022);
    queue_op(fse_pkg::MODE_PUSH,     '1,              0,    0);
    queue_op(fse_pkg::MODE_PEEK,     '0,              1023, 0);
    queue_op(fse_pkg::MODE_PEEK,     '0,              1024, 0);
    queue_op(fse_pkg::MODE_PEEK_REL, '0,              1024, 0);
    queue_op(fse_pkg::MODE_POKE,     '1,              1023, 0);
    queue_op(fse_pkg::MODE_POP,      '0,              0,    0);
    queue_op(fse_pkg::MODE_FREE,     '0,              0,    1024);
    queue_op(fse_pkg::MODE_FREE,     '0,              0,    1023);
    queue_op(fse_pkg::MODE_ALLOC,    '0,              0,    1024);
    queue_op(fse_pkg::MODE_FREE,     '0,              0,    1024);

    // Mostly operations that succeed on the current frame, with misses mixed in.
    for (int n = 0; n < 1750; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22)      m = fse_pkg::MODE_PUSH;
      else if (pick < 40) m = fse_pkg::MODE_POP;
      else if (pick < 48) m = fse_pkg::MODE_ALLOC;
      else if (pick < 56) m = fse_pkg::MODE_FREE;
      else if (pick < 68) m = fse_pkg::MODE_PEEK;
      else if (pick < 78) m = fse_pkg::MODE_PEEK_REL;
      else if (pick < 88) m = fse_pkg::MODE_POKE;
      else                m = fse_pkg::MODE_POKE_REL;
      pick = $urandom_range(0, 19);
      if (pick < 2)       val = '1;
      else if (pick == 2) val = '0;
      else                val = {$urandom, $urandom};
      pos = $urandom_range(0, 1024);
      amt = $urandom_range(0, 1024);
      if ((m inside {fse_pkg::MODE_PEEK, fse_pkg::MODE_POKE}) && gen_top > 0 &&
          $urandom_range(0, 99) < 85) begin
        pos = $urandom_range(0, gen_top - 1);
      end else if ((m inside {fse_pkg::MODE_PEEK_REL, fse_pkg::MODE_POKE_REL}) &&
                   gen_top > 0 && $urandom_range(0, 99) < 85) begin
        pos = $urandom_range(1, gen_top);
      end
      if (m == fse_pkg::MODE_ALLOC) begin
        pick = $urandom_range(0, 99);
        if (pick < 15)      amt = $urandom_range(0, DEPTH - gen_top);
        else if (pick < 25) amt = DEPTH - gen_top;
        else if (pick < 85) amt = $urandom_range(0, 8);
      end else if (m == fse_pkg::MODE_FREE) begin
        pick = $urandom_range(0, 99);
        if (pick < 10)      amt = gen_top;
        else if (pick < 80) amt = $urandom_range(0, (gen_top < 8) ? gen_top : 8);
        else if (pick < 90) amt = $urandom_range(0, 12);
      end
      queue_op(m, val, pos, amt);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() > 0 || req_if.valid) @(posedge clk_i);
    while (expected_rsps.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d results: %0d ok, %0d overflow, %0d underflow, %0d out of range",
             n_checked, status_seen[fse_pkg::ST_OK], status_seen[fse_pkg::ST_OVER],
             status_seen[fse_pkg::ST_UNDER], status_seen[fse_pkg::ST_RANGE]);
    $display("Mismatches: %0d, cycles: %0d", n_errors, cycles);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: frame_stack_engine.f
src/fse_pkg.sv
src/fse_in_if.sv
src/fse_out_if.sv
src/fse_ram.sv
src/fse_ctrl.sv
src/fse_resp.sv
src/frame_stack_engine.sv
dv/frame_stack_engine_tb.sv
